// ===== hw/rtl/mbra_pkg.sv =====
// shared types, constants and the pini gate function for the masked bitslice adder
// no dependencies; used by every module under hw/rtl
package mbra_pkg;

  localparam int NUM_SHARES    = 3;
  localparam int SLICE_WIDTH   = 32;
  localparam int FIELD_W       = 32;
  localparam int SHARE_FIELDS  = 3;
  localparam int MAX_WORD_BITS = 32;
  localparam int POS_W         = 6;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 6;
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W    = $clog2(FIFO_DEPTH + 1);

  localparam logic [FIELD_W-1:0] SLICE_MASK =
    (SLICE_WIDTH >= FIELD_W) ? {FIELD_W{1'b1}}
                             : FIELD_W'((64'd1 << SLICE_WIDTH) - 64'd1);

  typedef logic [FIELD_W-1:0] slice_t;
  typedef slice_t [SHARE_FIELDS-1:0] shares_t;
  typedef logic [POS_W-1:0] pos_t;

  typedef struct packed {
    shares_t sum;
    pos_t    index;
    logic    last;
  } result_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WORD_BITS = 1'b0,
    REG_CARRY_OUT = 1'b1
  } cfg_reg_t;

  // g(a,b,r) = (r & ~a) ^ (a & (b ^ r))
  function automatic slice_t pini_gate(slice_t a, slice_t b, slice_t r);
    return ((r & ~a) ^ (a & (b ^ r))) & SLICE_MASK;
  endfunction

endpackage

// ===== hw/rtl/masked_bitslice_ripple_adder.sv =====
// path: an accepted slice beat goes through the input register, then one pass of gadget logic
//   into the result queue, then out of the queue as a result beat
// throughput: one slice per cycle unless in_stall; the last slice with carry out gives two
//   result beats; output moves one beat per cycle unless out_stall, via a four-entry result queue
// reset (synchronous): carry shares and bit position cleared, word_bits 32, carry out on
// top level of the masked bitslice ripple-carry adder; uses mbra_pkg, mbra_and_gadget, mbra_out_fifo
module masked_bitslice_ripple_adder (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [mbra_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mbra_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [mbra_pkg::FIELD_W-1:0]       in1_share0,
  input  logic [mbra_pkg::FIELD_W-1:0]       in1_share1,
  input  logic [mbra_pkg::FIELD_W-1:0]       in1_share2,
  input  logic [mbra_pkg::FIELD_W-1:0]       in2_share0,
  input  logic [mbra_pkg::FIELD_W-1:0]       in2_share1,
  input  logic [mbra_pkg::FIELD_W-1:0]       in2_share2,
  input  logic [mbra_pkg::FIELD_W-1:0]       rand_pair01,
  input  logic [mbra_pkg::FIELD_W-1:0]       rand_pair02,
  input  logic [mbra_pkg::FIELD_W-1:0]       rand_pair12,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [mbra_pkg::FIELD_W-1:0]       sum_share0,
  output logic [mbra_pkg::FIELD_W-1:0]       sum_share1,
  output logic [mbra_pkg::FIELD_W-1:0]       sum_share2,
  output logic [mbra_pkg::POS_W-1:0]         slice_index,
  output logic                               last_slice
);

  logic [mbra_pkg::POS_W-1:0] word_bits;
  logic                       carry_out_enable;

  logic              stg_valid;
  mbra_pkg::shares_t stg_a;
  mbra_pkg::shares_t stg_b;
  mbra_pkg::shares_t stg_r;
  mbra_pkg::shares_t in_a;
  mbra_pkg::shares_t in_b;

  mbra_pkg::shares_t carry_shares;
  mbra_pkg::shares_t carry_shares_next;
  mbra_pkg::pos_t    bit_position;
  mbra_pkg::pos_t    bit_position_next;

  mbra_pkg::pos_t    kb;
  logic              step_last;
  logic              need_carry;
  logic              move;
  logic              accept;
  logic              room;

  mbra_pkg::shares_t xpy;
  mbra_pkg::shares_t ga;
  mbra_pkg::shares_t gb;
  mbra_pkg::shares_t gz;
  mbra_pkg::shares_t nc;
  mbra_pkg::shares_t sum;

  mbra_pkg::result_t res0;
  mbra_pkg::result_t res1;
  mbra_pkg::result_t dout;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      word_bits        <= mbra_pkg::POS_W'(mbra_pkg::MAX_WORD_BITS);
      carry_out_enable <= 1'b1;
    end else if (cfg_write) begin
      unique case (mbra_pkg::cfg_reg_t'(cfg_index))
        mbra_pkg::REG_WORD_BITS: word_bits        <= cfg_data;
        mbra_pkg::REG_CARRY_OUT: carry_out_enable <= cfg_data[0];
      endcase
    end
  end

  // input register, unused shares forced to zero
  always_comb begin
    in_a = {in1_share2, in1_share1, in1_share0};
    in_b = {in2_share2, in2_share1, in2_share0};
    for (int d = 0; d < mbra_pkg::SHARE_FIELDS; d++) begin
      if (d < mbra_pkg::NUM_SHARES) begin
        in_a[d] = in_a[d] & mbra_pkg::SLICE_MASK;
        in_b[d] = in_b[d] & mbra_pkg::SLICE_MASK;
      end else begin
        in_a[d] = '0;
        in_b[d] = '0;
      end
    end
  end

  assign move     = stg_valid && room;
  assign in_stall = stg_valid && !room;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (accept) begin
      stg_valid <= 1'b1;
    end else if (move) begin
      stg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg_a <= in_a;
      stg_b <= in_b;
      stg_r <= {rand_pair12, rand_pair02, rand_pair01};
    end
  end

  // slice step
  always_comb begin
    if (word_bits == '0) begin
      kb = mbra_pkg::POS_W'(1);
    end else if (word_bits > mbra_pkg::POS_W'(mbra_pkg::MAX_WORD_BITS)) begin
      kb = mbra_pkg::POS_W'(mbra_pkg::MAX_WORD_BITS);
    end else begin
      kb = word_bits;
    end
    step_last  = ({1'b0, bit_position} + 7'd1) >= {1'b0, kb};
    need_carry = !step_last || carry_out_enable;
  end

  always_comb begin
    for (int d = 0; d < mbra_pkg::SHARE_FIELDS; d++) begin
      xpy[d] = stg_a[d] ^ stg_b[d];
      if (bit_position == '0) begin
        ga[d]  = stg_a[d];
        gb[d]  = stg_b[d];
        sum[d] = xpy[d];
      end else begin
        // carry = and(a^b, a^c) ^ a
        ga[d]  = xpy[d];
        gb[d]  = stg_a[d] ^ carry_shares[d];
        sum[d] = xpy[d] ^ carry_shares[d];
      end
    end
  end

  mbra_and_gadget u_gadget (
    .a   (ga),
    .b   (gb),
    .rnd (stg_r),
    .z   (gz)
  );

  always_comb begin
    for (int d = 0; d < mbra_pkg::SHARE_FIELDS; d++) begin
      nc[d] = (bit_position == '0) ? gz[d] : ((gz[d] ^ stg_a[d]) & mbra_pkg::SLICE_MASK);
    end
    carry_shares_next = (move && need_carry) ? nc : carry_shares;
    if (move) begin
      bit_position_next = step_last ? '0 : bit_position + mbra_pkg::POS_W'(1);
    end else begin
      bit_position_next = bit_position;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      carry_shares <= '0;
      bit_position <= '0;
    end else begin
      carry_shares <= carry_shares_next;
      bit_position <= bit_position_next;
    end
  end

  always_comb begin
    res0.sum   = sum;
    res0.index = bit_position;
    res0.last  = step_last && !carry_out_enable;
    res1.sum   = nc;
    res1.index = kb;
    res1.last  = 1'b1;
  end

  mbra_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_one  (move),
    .push_two  (move && step_last && carry_out_enable),
    .din0      (res0),
    .din1      (res1),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dout      (dout)
  );

  assign sum_share0  = dout.sum[0];
  assign sum_share1  = dout.sum[1];
  assign sum_share2  = dout.sum[2];
  assign slice_index = dout.index;
  assign last_slice  = dout.last;

  a_wrap_to_zero: assert property (@(posedge clk) disable iff (rst)
    move && step_last |=> bit_position == '0)
    else $error("bit position not cleared after last slice");

  a_carry_idle: assert property (@(posedge clk) disable iff (rst)
    !move |=> $stable(carry_shares) && $stable(bit_position))
    else $error("slice state changed without a slice");

  a_carry_kept: assert property (@(posedge clk) disable iff (rst)
    move && step_last && !carry_out_enable |=> $stable(carry_shares))
    else $error("carry changed on last slice without carry out");

  a_stall_only_held: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> stg_valid && !move)
    else $error("input stalled with empty input register");

endmodule

// ===== hw/rtl/mbra_and_gadget.sv =====
// masked and gadget: per-share products plus one pini gate pair per share pair
// depends on mbra_pkg
module mbra_and_gadget (
  input  mbra_pkg::shares_t a,
  input  mbra_pkg::shares_t b,
  input  mbra_pkg::shares_t rnd,
  output mbra_pkg::shares_t z
);

  always_comb begin
    mbra_pkg::shares_t t;
    mbra_pkg::slice_t  r;
    int k;
    k = 0;
    for (int i = 0; i < mbra_pkg::SHARE_FIELDS; i++) begin
      t[i] = a[i] & b[i];
    end
    // pairs (0,1), (0,2), (1,2) take random words 0, 1, 2 in that order
    for (int i = 0; i < mbra_pkg::SHARE_FIELDS - 1; i++) begin
      for (int j = i + 1; j < mbra_pkg::SHARE_FIELDS; j++) begin
        if (j < mbra_pkg::NUM_SHARES) begin
          r = rnd[k] & mbra_pkg::SLICE_MASK;
          t[i] = t[i] ^ mbra_pkg::pini_gate(a[i], b[j], r);
          t[j] = t[j] ^ mbra_pkg::pini_gate(a[j], b[i], r);
        end
        k = k + 1;
      end
    end
    z = t;
  end

endmodule

// ===== hw/rtl/mbra_out_fifo.sv =====
// result queue: takes one or two result beats per cycle, hands out one per cycle unless out_stall
// depends on mbra_pkg
module mbra_out_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_one,
  input  logic               push_two,
  input  mbra_pkg::result_t  din0,
  input  mbra_pkg::result_t  din1,
  output logic               room,
  output logic               out_valid,
  input  logic               out_stall,
  output mbra_pkg::result_t  dout
);

  mbra_pkg::result_t mem [mbra_pkg::FIFO_DEPTH];
  logic [mbra_pkg::FIFO_PTR_W-1:0] wr_ptr;
  logic [mbra_pkg::FIFO_PTR_W-1:0] rd_ptr;
  logic [mbra_pkg::FIFO_CNT_W-1:0] count;
  logic [mbra_pkg::FIFO_CNT_W-1:0] count_next;
  logic pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && !out_stall;
  assign dout      = mem[rd_ptr];
  // room for a two-beat item
  assign room      = (count <= mbra_pkg::FIFO_CNT_W'(mbra_pkg::FIFO_DEPTH - 2));

  always_comb begin
    count_next = count + mbra_pkg::FIFO_CNT_W'(push_one) + mbra_pkg::FIFO_CNT_W'(push_two)
                 - mbra_pkg::FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_one) begin
      mem[wr_ptr] <= din0;
    end
    if (push_two) begin
      mem[wr_ptr + mbra_pkg::FIFO_PTR_W'(1)] <= din1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + mbra_pkg::FIFO_PTR_W'(push_one) + mbra_pkg::FIFO_PTR_W'(push_two);
      if (pop) begin
        rd_ptr <= rd_ptr + mbra_pkg::FIFO_PTR_W'(1);
      end
      count <= count_next;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= mbra_pkg::FIFO_CNT_W'(mbra_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  a_two_needs_one: assert property (@(posedge clk) disable iff (rst)
    push_two |-> push_one && room)
    else $error("second beat pushed without first or without room");

  a_count_tracks: assert property (@(posedge clk) disable iff (rst)
    push_one && !pop |=> count == $past(count) + mbra_pkg::FIFO_CNT_W'(1)
                                  + mbra_pkg::FIFO_CNT_W'($past(push_two)))
    else $error("queue count lost a beat");

endmodule
